>>> design/ebws_pkg.sv
// Shared constants, segment timing and controller/datapath interface types.
package ebws_pkg;

   // Brightness request width and the mask applied to each request
   localparam int BRIGHTNESS_BITS = 16;
   localparam int BRIGHT_W = 16;
   localparam logic [BRIGHT_W-1:0] BRIGHT_MASK =
      BRIGHT_W'((33'd1 << BRIGHTNESS_BITS) - 33'd1);

   localparam int STEPS_W = 8;
   localparam int ADDR_W = 8;
   localparam int PROD_W = STEPS_W + BRIGHT_W;
   localparam int QUOT_W = 8;
   localparam int DIV_CNT_W = 3;
   localparam int SEG_W = 6;
   localparam int DUR_W = 14;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEPS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd2;

   localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = 8'd31;
   localparam logic [BRIGHT_W-1:0] BRIGHT_LIMIT_RESET = 16'd255;
   localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 8'h72;

   // Segment durations in microseconds
   localparam logic [DUR_W-1:0] T_POWER_UP = 14'd10000;
   localparam logic [DUR_W-1:0] T_WAKE_DELAY = 14'd150;
   localparam logic [DUR_W-1:0] T_ES_DETECT = 14'd300;
   localparam logic [DUR_W-1:0] T_ES_WINDOW = 14'd2000;
   localparam logic [DUR_W-1:0] T_OFF = 14'd3000;
   localparam logic [DUR_W-1:0] T_START = 14'd3;
   localparam logic [DUR_W-1:0] T_EOS = 14'd3;
   localparam logic [DUR_W-1:0] T_SHORT = 14'd3;
   localparam logic [DUR_W-1:0] T_LONG = 14'd8;
   localparam logic [DUR_W-1:0] T_HOLD = 14'd0;

   // Segment numbering: power-up, address byte, level byte, hold, shutdown
   localparam logic [SEG_W-1:0] SEG_POWER_UP = 6'd0;
   localparam logic [SEG_W-1:0] SEG_ADDR_BYTE = 6'd4;
   localparam logic [SEG_W-1:0] SEG_LEVEL_BYTE = 6'd22;
   localparam logic [SEG_W-1:0] SEG_HOLD = 6'd40;
   localparam logic [SEG_W-1:0] SEG_OFF = 6'd41;
   localparam logic [SEG_W-1:0] SEG_OFF_HOLD = 6'd42;
   localparam logic [4:0] BYTE_EOS = 5'd17;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic fix;
      logic seg_load;
      logic [SEG_W-1:0] seg_start;
      logic seg_adv;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic zero;
      logic div_last;
      logic seg_last;
   } status_type;

endpackage

>>> design/ebws_dp.sv
// Datapath: config registers, clamp, scale divider and segment decode.
module ebws_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ebws_pkg::cmd_type                   cmd,
   output ebws_pkg::status_type                status,
   input  logic [ebws_pkg::BRIGHT_W-1:0]       req_brightness,
   input  logic                                csr_write,
   input  logic [ebws_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ebws_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_ctrl_level,
   output logic                                rsp_power_enable,
   output logic [ebws_pkg::DUR_W-1:0]          rsp_duration_us,
   output logic                                rsp_last
);

   logic [ebws_pkg::STEPS_W-1:0]   steps_ff;
   logic [ebws_pkg::BRIGHT_W-1:0]  maxb_ff;
   logic [ebws_pkg::ADDR_W-1:0]    addr_ff;
   logic [ebws_pkg::BRIGHT_W-1:0]  b_ff, b_in;
   logic [ebws_pkg::PROD_W-1:0]    rem_ff, div_ff;
   logic [ebws_pkg::QUOT_W-1:0]    quot_ff, level_ff;
   logic [ebws_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [ebws_pkg::SEG_W-1:0]     seg_ff;
   logic                           rem_ge;

   // Configuration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= ebws_pkg::MAX_STEPS_RESET;
         maxb_ff  <= ebws_pkg::BRIGHT_LIMIT_RESET;
         addr_ff  <= ebws_pkg::DEVICE_ADDRESS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ebws_pkg::CSR_MAX_STEPS:      steps_ff <= csr_wdata[ebws_pkg::STEPS_W-1:0];
            ebws_pkg::CSR_BRIGHT_LIMIT:   maxb_ff <= csr_wdata;
            ebws_pkg::CSR_DEVICE_ADDRESS: addr_ff <= csr_wdata[ebws_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Mask and clamp the request
   always_comb begin
      b_in = req_brightness & ebws_pkg::BRIGHT_MASK;
      if (b_in > maxb_ff) b_in = maxb_ff;
   end

   assign rem_ge = (rem_ff >= div_ff);

   // Multiply, then restoring division one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            b_ff    <= b_in;
            div_ff  <= {1'b0, maxb_ff, 7'd0};
            quot_ff <= '0;
            cnt_ff  <= '0;
         end
         if (cmd.mul) begin
            rem_ff <= steps_ff * b_ff;
         end
         if (cmd.div_step) begin
            if (rem_ge) rem_ff <= rem_ff - div_ff;
            quot_ff <= {quot_ff[ebws_pkg::QUOT_W-2:0], rem_ge};
            div_ff  <= div_ff >> 1;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         // Level is bumped by one below the top step
         if (cmd.fix) begin
            level_ff <= (quot_ff < steps_ff) ? quot_ff + 1'b1 : quot_ff;
         end
         if (cmd.seg_load) begin
            seg_ff <= cmd.seg_start;
         end else if (cmd.seg_adv) begin
            seg_ff <= seg_ff + 1'b1;
         end
      end
   end

   // Segment decode from the running segment number
   always_comb begin
      logic                          in_level;
      logic [4:0]                    k;
      logic [3:0]                    j;
      logic [ebws_pkg::ADDR_W-1:0]   byte_v;
      logic                          bit_v;

      in_level = (seg_ff >= ebws_pkg::SEG_LEVEL_BYTE);
      k = in_level ? 5'(seg_ff - ebws_pkg::SEG_LEVEL_BYTE)
                   : 5'(seg_ff - ebws_pkg::SEG_ADDR_BYTE);
      j = 4'(k - 5'd1);
      byte_v = in_level ? level_ff : addr_ff;
      bit_v = byte_v[~j[3:1]];

      rsp_power_enable = 1'b1;
      rsp_ctrl_level   = 1'b0;
      rsp_duration_us  = ebws_pkg::T_HOLD;

      if (seg_ff < ebws_pkg::SEG_ADDR_BYTE) begin
         case (seg_ff[1:0])
            2'd0: begin rsp_ctrl_level = 1'b0; rsp_duration_us = ebws_pkg::T_POWER_UP; end
            2'd1: begin rsp_ctrl_level = 1'b1; rsp_duration_us = ebws_pkg::T_WAKE_DELAY; end
            2'd2: begin rsp_ctrl_level = 1'b0; rsp_duration_us = ebws_pkg::T_ES_DETECT; end
            default: begin rsp_ctrl_level = 1'b1; rsp_duration_us = ebws_pkg::T_ES_WINDOW; end
         endcase
      end else if (seg_ff < ebws_pkg::SEG_HOLD) begin
         if (k == 5'd0) begin
            rsp_ctrl_level  = 1'b1;
            rsp_duration_us = ebws_pkg::T_START;
         end else if (k == ebws_pkg::BYTE_EOS) begin
            rsp_ctrl_level  = 1'b0;
            rsp_duration_us = ebws_pkg::T_EOS;
         end else if (!j[0]) begin
            // low half of a bit: short for a one
            rsp_ctrl_level  = 1'b0;
            rsp_duration_us = bit_v ? ebws_pkg::T_SHORT : ebws_pkg::T_LONG;
         end else begin
            rsp_ctrl_level  = 1'b1;
            rsp_duration_us = bit_v ? ebws_pkg::T_LONG : ebws_pkg::T_SHORT;
         end
      end else if (seg_ff == ebws_pkg::SEG_HOLD) begin
         rsp_ctrl_level = 1'b1;
      end else if (seg_ff == ebws_pkg::SEG_OFF) begin
         rsp_duration_us = ebws_pkg::T_OFF;
      end else begin
         rsp_power_enable = 1'b0;
      end
   end

   assign rsp_last = (seg_ff == ebws_pkg::SEG_HOLD) || (seg_ff == ebws_pkg::SEG_OFF_HOLD);

   assign status.zero     = (b_ff == '0);
   assign status.div_last = (cnt_ff == {ebws_pkg::DIV_CNT_W{1'b1}});
   assign status.seg_last = rsp_last;

endmodule

>>> design/ebws_ctrl.sv
// Controller: request sequencing, converter power state and result handshake.
module ebws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ebws_pkg::cmd_type    cmd,
   input  ebws_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FIX,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      on_ff, on_in;
   logic      valid_ff, valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      on_in    = on_ff;
      valid_in = valid_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.zero) begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end else if (on_ff) begin
               // shutdown of a running converter
               cmd.seg_load  = 1'b1;
               cmd.seg_start = ebws_pkg::SEG_OFF;
               on_in    = 1'b0;
               valid_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix       = 1'b1;
            cmd.seg_load  = 1'b1;
            cmd.seg_start = on_ff ? ebws_pkg::SEG_ADDR_BYTE : ebws_pkg::SEG_POWER_UP;
            on_in    = 1'b1;
            valid_in = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (status.seg_last) begin
                  valid_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  cmd.seg_adv = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         on_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         on_ff    <= on_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> design/easyscale_backlight_wire_sequencer.sv
// Top level: one-wire backlight sequencer, controller plus datapath.
//
// A brightness item enters on req_valid/req_ready. It is masked, clamped to
// the brightness limit and scaled to a level code with an 8-step restoring
// divider.
// The item then leaves as a list of pin segments on rsp_valid/rsp_ready, one
// segment per cycle while rsp_ready is high; rsp_last marks the final one.
// A converter that is off gets the four power-up segments first, then the
// address byte, the level byte and a hold segment (up to 41 segments).
// Zero brightness on a running converter gives a 3000 us low and an
// enable-off hold; zero brightness while off gives no segments.
// The item is clamped at the accepting edge, then the multiply, eight divide
// steps and the level fixup run before rsp_valid rises.
// One item is in work at a time; req_ready is low until the last segment
// is taken. A stalled receiver holds the current segment unchanged.
// Configuration writes (csr_*) are always taken and are meant for idle time.
// Reset restores the register defaults and marks the converter off.
module easyscale_backlight_wire_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ebws_pkg::BRIGHT_W-1:0]    req_brightness,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ctrl_level,
   output logic                             rsp_power_enable,
   output logic [ebws_pkg::DUR_W-1:0]       rsp_duration_us,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ebws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ebws_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ebws_pkg::cmd_type    cmd;
   ebws_pkg::status_type status;

   assign csr_ready = 1'b1;

   ebws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ebws_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_brightness   (req_brightness),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ctrl_level   (rsp_ctrl_level),
      .rsp_power_enable (rsp_power_enable),
      .rsp_duration_us  (rsp_duration_us),
      .rsp_last         (rsp_last)
   );

endmodule

>>> design/ebws_chk.sv
// Port-level checker for the sequencer, bound to the top level.
module ebws_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_ctrl_level,
   input logic                             rsp_power_enable,
   input logic [ebws_pkg::DUR_W-1:0]       rsp_duration_us,
   input logic                             rsp_last
);

   // A stalled segment holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duration_us)
         && $stable(rsp_ctrl_level) && $stable(rsp_power_enable) && $stable(rsp_last))
      else $error("segment changed while stalled");

   // No new item is taken while segments are pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken during segment output");

   // Scaling takes time: no segment right after an item is taken
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("segment too early after request");

   // Output stops after the final segment
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("segment after last");

   // Only the closing hold segment has zero length
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duration_us == '0 |-> rsp_last)
      else $error("hold segment not marked last");

endmodule

bind easyscale_backlight_wire_sequencer ebws_chk u_ebws_chk (.*);

>>> tb/sv/ebws_segment_checker.sv
// Segment checker: predicts the pin segments of each brightness item and compares them.
`timescale 1ns / 100ps
module ebws_segment_checker
   import ebws_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [BRIGHT_W-1:0]    req_brightness,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_ctrl_level,
   input  logic                   rsp_power_enable,
   input  logic [DUR_W-1:0]       rsp_duration_us,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     segments_pending
);

   typedef struct packed {
      logic             ctrl_level;
      logic             power_enable;
      logic [DUR_W-1:0] duration_us;
      logic             last;
   } segment_type;

   // Segments still owed by the block, oldest first
   segment_type expected_segments[$];

   // Shadow copy of the registers and the converter state
   logic [STEPS_W-1:0]  max_steps_q;
   logic [BRIGHT_W-1:0] bright_limit_q;
   logic [ADDR_W-1:0]   address_q;
   logic                converter_on;
   int                  errors;

   function automatic void add_segment(input logic ctrl, input logic enable,
                                       input logic [DUR_W-1:0] duration,
                                       input logic last = 1'b0);
      expected_segments.push_back('{ctrl_level: ctrl, power_enable: enable,
                                    duration_us: duration, last: last});
   endfunction

   // Start bit, eight data bits MSB first, end-of-stream low
   function automatic void add_wire_byte(input logic [7:0] value);
      int i;
      add_segment(1'b1, 1'b1, T_START);
      for (i = 7; i >= 0; i--) begin
         if (value[i]) begin
            add_segment(1'b0, 1'b1, T_SHORT);
            add_segment(1'b1, 1'b1, T_LONG);
         end else begin
            add_segment(1'b0, 1'b1, T_LONG);
            add_segment(1'b1, 1'b1, T_SHORT);
         end
      end
      add_segment(1'b0, 1'b1, T_EOS);
   endfunction

   // Expected segments for one brightness request
   function automatic void plan_segments(input logic [BRIGHT_W-1:0] request);
      logic [BRIGHT_W-1:0] clamped;
      logic [PROD_W-1:0]   product;
      logic [STEPS_W-1:0]  level;
      clamped = request & BRIGHT_MASK;
      if (clamped > bright_limit_q)
         clamped = bright_limit_q;
      if (clamped != '0) begin
         product = max_steps_q * clamped;
         level = STEPS_W'(product / bright_limit_q);
         if (level < max_steps_q)
            level = level + 1'b1;
         // power-up handshake only when the converter is off
         if (!converter_on) begin
            add_segment(1'b0, 1'b1, T_POWER_UP);
            add_segment(1'b1, 1'b1, T_WAKE_DELAY);
            add_segment(1'b0, 1'b1, T_ES_DETECT);
            add_segment(1'b1, 1'b1, T_ES_WINDOW);
            converter_on = 1'b1;
         end
         add_wire_byte(address_q);
         add_wire_byte(level);
         add_segment(1'b1, 1'b1, T_HOLD, 1'b1);
      end else if (converter_on) begin
         // shutdown; an off request on an idle converter gives nothing
         add_segment(1'b0, 1'b1, T_OFF);
         add_segment(1'b0, 1'b0, T_HOLD, 1'b1);
         converter_on = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         expected_segments.delete();
         max_steps_q = MAX_STEPS_RESET;
         bright_limit_q = BRIGHT_LIMIT_RESET;
         address_q = DEVICE_ADDRESS_RESET;
         converter_on = 1'b0;
         errors = 0;
      end else begin
         // compare results first: only one item is in work at a time
         if (rsp_valid && rsp_ready) begin
            if (expected_segments.size() == 0) begin
               $error("segment with no item pending: ctrl %0d enable %0d dur %0d last %0d",
                      rsp_ctrl_level, rsp_power_enable, rsp_duration_us, rsp_last);
               errors++;
            end else begin
               want = expected_segments.pop_front();
               if (rsp_ctrl_level !== want.ctrl_level) begin
                  $error("ctrl_level: expected %0d, actual %0d",
                         want.ctrl_level, rsp_ctrl_level);
                  errors++;
               end
               if (rsp_power_enable !== want.power_enable) begin
                  $error("power_enable: expected %0d, actual %0d",
                         want.power_enable, rsp_power_enable);
                  errors++;
               end
               if (rsp_duration_us !== want.duration_us) begin
                  $error("duration_us: expected %0d, actual %0d",
                         want.duration_us, rsp_duration_us);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  errors++;
               end
            end
         end
         // register writes; unused index is ignored
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_STEPS:      max_steps_q = csr_wdata[STEPS_W-1:0];
               CSR_BRIGHT_LIMIT:   bright_limit_q = csr_wdata[BRIGHT_W-1:0];
               CSR_DEVICE_ADDRESS: address_q = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            plan_segments(req_brightness);
      end
      mismatch_count <= errors;
      segments_pending <= expected_segments.size();
   end

endmodule

>>> tb/sv/easyscale_backlight_wire_sequencer_tb.sv
// Testbench top: clock, reset, brightness and register stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module easyscale_backlight_wire_sequencer_tb;
   import ebws_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 57;
   localparam int PAUSE_AT_ITEM = 28;
   localparam int NO_IDLE_PHASE = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BRIGHT_W-1:0]    req_brightness = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_ctrl_level;
   logic                   rsp_power_enable;
   logic [DUR_W-1:0]       rsp_duration_us;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     mismatch_count;
   int                     segments_pending;
   int                     quiet_cycles = 0;
   logic                   idling_on = 1'b1;
   logic [BRIGHT_W-1:0]    brightness_ceiling = BRIGHT_LIMIT_RESET;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   easyscale_backlight_wire_sequencer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_brightness   (req_brightness),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ctrl_level   (rsp_ctrl_level),
      .rsp_power_enable (rsp_power_enable),
      .rsp_duration_us  (rsp_duration_us),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   ebws_segment_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_brightness   (req_brightness),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ctrl_level   (rsp_ctrl_level),
      .rsp_power_enable (rsp_power_enable),
      .rsp_duration_us  (rsp_duration_us),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .segments_pending (segments_pending)
   );

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= !idling_on || ($urandom_range(0, 99) >= 33);
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One brightness item, with an optional gap before it
   task automatic send_brightness(input logic [BRIGHT_W-1:0] value);
      if (idling_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 33);
      end
      req_valid <= 1'b1;
      req_brightness <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every owed segment has arrived
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (segments_pending != 0);
   endtask

   // Drained plus the block's latency, so no item is still in work
   task automatic settle();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] steps_word,
                                 input logic [CSR_DATA_W-1:0] bmax,
                                 input logic [CSR_DATA_W-1:0] addr_word);
      settle();
      write_register(CSR_MAX_STEPS, steps_word);
      write_register(CSR_BRIGHT_LIMIT, bmax);
      write_register(CSR_DEVICE_ADDRESS, addr_word);
      brightness_ceiling = (bmax == '0) ? 16'd1 : bmax;
   endtask

   // Random settings, extremes included; upper data bits of byte registers are junk
   task automatic apply_random_settings();
      logic [STEPS_W-1:0]  steps;
      logic [BRIGHT_W-1:0] bmax;
      case ($urandom_range(0, 3))
         0: steps = 8'd1;
         1: steps = 8'd255;
         default: steps = 8'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 3))
         0: bmax = 16'd1;
         1: bmax = 16'hFFFF;
         2: bmax = 16'($urandom_range(1, 300));
         default: bmax = 16'($urandom_range(1, 65535));
      endcase
      apply_settings({8'($urandom), steps}, bmax, 16'($urandom));
   endtask

   // Mostly in-range requests, some zeros, some above the clamp
   function automatic logic [BRIGHT_W-1:0] pick_brightness();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return BRIGHT_W'($urandom);
         2: return brightness_ceiling;
         default: return BRIGHT_W'($urandom_range(1, brightness_ceiling));
      endcase
   endfunction

   initial begin
      int phase;
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: off request while off, power-up, clamp, shutdown twice
      send_brightness(16'd0);
      send_brightness(16'd255);
      send_brightness(16'd1);
      send_brightness(16'hFFFF);
      send_brightness(16'd128);
      send_brightness(16'd0);
      send_brightness(16'd0);
      send_brightness(16'h8000);
      send_brightness(16'd0);

      // widest scale, all-ones address
      apply_settings(16'hABFF, 16'hFFFF, 16'h00FF);
      send_brightness(16'hFFFF);
      send_brightness(16'd1);
      send_brightness(16'h5555);
      send_brightness(16'hAAAA);
      send_brightness(16'd0);

      // narrowest scale, zero address
      apply_settings(16'd1, 16'd1, 16'd0);
      send_brightness(16'd1);
      send_brightness(16'd2);
      send_brightness(16'd0);

      // zero step count: level stays zero
      apply_settings(16'hFF00, 16'd1000, 16'h0072);
      send_brightness(16'd1000);
      send_brightness(16'd999);

      // zero brightness limit: every request acts as an off request
      apply_settings(16'd31, 16'd0, 16'h0072);
      write_register(CSR_UNUSED, 16'hFFFF);
      send_brightness(16'd5);
      send_brightness(16'hFFFF);
      send_brightness(16'd1);

      // random phases, one without any idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_random_settings();
         idling_on <= (phase != NO_IDLE_PHASE);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == PAUSE_AT_ITEM)
               pause_until_drained();
            send_brightness(pick_brightness());
         end
      end

      settle();
      if (mismatch_count == 0 && segments_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
